// ===== rtl/core/frs_pkg.sv =====
// Shared types and register index codes for the fractional pixel replication scaler.
package frs_pkg;

    // Configuration port widths
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 19;

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_REPEAT_WHOLE = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_EXTRA_NUM    = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_EXTRA_DEN    = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_IN_WIDTH     = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_IN_HEIGHT    = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_OUT_HEIGHT   = 3'd5;

    // Reset values of the configuration registers
    localparam logic [5:0]  RST_REPEAT_WHOLE = 6'd1;
    localparam logic [6:0]  RST_EXTRA_NUM    = 7'd0;
    localparam logic [6:0]  RST_EXTRA_DEN    = 7'd0;
    localparam logic [11:0] RST_IN_WIDTH     = 12'd1;
    localparam logic [12:0] RST_IN_HEIGHT    = 13'd1;
    localparam logic [18:0] RST_OUT_HEIGHT   = 19'd1;

    // Input item: new pixel or replay request
    typedef struct packed {
        logic       action;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } frs_in_t;

    // Result item: one output pixel copy
    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic       last;
        logic       line_end;
        logic       rejected;
    } frs_out_t;

    // Configuration register file contents
    typedef struct packed {
        logic [5:0]  repeat_whole;
        logic [6:0]  extra_num;
        logic [6:0]  extra_den;
        logic [11:0] in_width;
        logic [12:0] in_height;
        logic [18:0] out_height;
    } frs_cfg_t;

    // Work handed from the control stage to the result stage
    typedef struct packed {
        logic        valid;
        logic [6:0]  copies;
        logic        row_end;
        logic        rejected;
        logic        from_mem;
        logic [23:0] pixel;
    } frs_load_t;

endpackage

// ===== rtl/core/fractional_pixel_replication_scaler.sv =====
// Top level of the fractional pixel replication scaler.
//
//  Channel  Handshake              Payload
//  in       in_valid / in_ready    in_item   (frs_in_t: action, blue, green, red)
//  out      out_valid / out_ready  out_item  (frs_out_t: pixel, last, line_end, rejected)
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item occupies the result register until all of its copies (1 to 64) have left;
// one copy leaves per cycle while out_ready is high. A new item is taken in the cycle its
// predecessor's final copy leaves, so unstalled one-copy items flow at one per cycle.
// Replay reads are issued to the line store's registered read port in the accepting cycle.
// Reset clears all counters and empties the result register; the line store is not cleared.
// A stall on out_ready holds the result and, on the final copy, holds off in_ready.
module fractional_pixel_replication_scaler #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  frs_pkg::frs_in_t            in_item,
    output logic                        out_valid,
    input  logic                        out_ready,
    output frs_pkg::frs_out_t           out_item,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [frs_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [frs_pkg::CFG_DW-1:0]  cfg_data
);
    import frs_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    frs_cfg_t      cfg;
    frs_load_t     load;
    logic          accept;
    logic          free;
    logic          wr_en;
    logic [CW-1:0] wr_addr;
    logic [23:0]   wr_data;
    logic          rd_en;
    logic [CW-1:0] rd_addr;
    logic [23:0]   rd_data;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign in_ready  = free;
    assign accept    = in_valid && free;

    frs_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    frs_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .item    (in_item),
        .cfg     (cfg),
        .load    (load),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr)
    );

    frs_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    frs_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .mem_data  (rd_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_item  (out_item),
        .free      (free)
    );

endmodule

// ===== rtl/core/frs_cfg.sv =====
// Configuration register file of the scaler.
module frs_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [frs_pkg::CFG_IW-1:0]    wr_index,
    input  logic [frs_pkg::CFG_DW-1:0]    wr_data,
    output frs_pkg::frs_cfg_t             cfg
);
    import frs_pkg::*;

    frs_cfg_t cfg_reg;
    frs_cfg_t cfg_next;

    // Register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_REPEAT_WHOLE: cfg_next.repeat_whole = wr_data[5:0];
                CFG_EXTRA_NUM:    cfg_next.extra_num    = wr_data[6:0];
                CFG_EXTRA_DEN:    cfg_next.extra_den    = wr_data[6:0];
                CFG_IN_WIDTH:     cfg_next.in_width     = wr_data[11:0];
                CFG_IN_HEIGHT:    cfg_next.in_height    = wr_data[12:0];
                CFG_OUT_HEIGHT:   cfg_next.out_height   = wr_data[18:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.repeat_whole <= RST_REPEAT_WHOLE;
            cfg_reg.extra_num    <= RST_EXTRA_NUM;
            cfg_reg.extra_den    <= RST_EXTRA_DEN;
            cfg_reg.in_width     <= RST_IN_WIDTH;
            cfg_reg.in_height    <= RST_IN_HEIGHT;
            cfg_reg.out_height   <= RST_OUT_HEIGHT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/frs_line_buf.sv =====
// Line store: one write port for live pixels, one registered read port for replays.
module frs_line_buf #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [23:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [23:0]   rd_data
);
    logic [23:0] mem [DEPTH];
    logic [23:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/frs_ctrl.sv =====
// Position and pattern counters: decides copies, row replays and line store access.
module frs_ctrl #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096,
    parameter int CW         = 11
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  frs_pkg::frs_in_t     item,
    input  frs_pkg::frs_cfg_t    cfg,
    output frs_pkg::frs_load_t   load,
    output logic                 wr_en,
    output logic [CW-1:0]        wr_addr,
    output logic [23:0]          wr_data,
    output logic                 rd_en,
    output logic [CW-1:0]        rd_addr
);
    import frs_pkg::*;

    localparam int WCLG = $clog2(MAX_WIDTH + 1);
    localparam int WVW  = (WCLG > 12) ? WCLG : 12;
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int HCLG = $clog2(MAX_HEIGHT + 1);
    localparam int HVW  = (HCLG > 13) ? HCLG : 13;
    localparam int NW   = HVW + 7;

    // Pattern counter step: returns {extra, next count}
    function automatic logic [7:0] pat_step(
        input logic [6:0] cnt,
        input logic       allowed,
        input logic [6:0] num,
        input logic [6:0] den
    );
        logic [6:0] inc;
        logic       extra;
        logic [6:0] nxt;
        inc   = cnt + 7'd1;
        extra = allowed && (inc != 7'd0) && (inc <= num);
        nxt   = (!extra && (inc == den)) ? 7'd0 : inc;
        return {extra, nxt};
    endfunction

    logic [CW-1:0] in_col_reg, in_col_next;
    logic [6:0]    col_pat_reg, col_pat_next;
    logic [RW-1:0] in_row_reg, in_row_next;
    logic [6:0]    row_pat_reg, row_pat_next;
    logic [RW-1:0] xrows_reg, xrows_next;
    logic [5:0]    replays_reg, replays_next;
    logic [CW-1:0] rep_col_reg, rep_col_next;
    logic [6:0]    rep_pat_reg, rep_pat_next;

    logic [5:0]     n_eff;
    logic [WVW-1:0] w_eff;
    logic [HVW-1:0] h_eff;

    logic [WVW-1:0] col_ext, col_clamp;
    logic           col_last;
    logic [WVW-1:0] rcol_ext, rcol_clamp;
    logic           rcol_last;
    logic [7:0]     col_step, rcol_step, row_step;
    logic [HVW-1:0] row_inc;
    logic           frame_end;
    logic [NW-1:0]  need;
    logic           row_fits;
    logic           replay_req, pending;
    logic [23:0]    pix_in;

    // Effective scale factor and frame size
    always_comb
    begin
        n_eff = (cfg.repeat_whole == 6'd0) ? 6'd1 : cfg.repeat_whole;
        if (cfg.in_width == 12'd0)
            w_eff = WVW'(1);
        else if (WVW'(cfg.in_width) > WVW'(MAX_WIDTH))
            w_eff = WVW'(MAX_WIDTH);
        else
            w_eff = WVW'(cfg.in_width);
        if (cfg.in_height == 13'd0)
            h_eff = HVW'(1);
        else if (HVW'(cfg.in_height) > HVW'(MAX_HEIGHT))
            h_eff = HVW'(MAX_HEIGHT);
        else
            h_eff = HVW'(cfg.in_height);
    end

    // Column positions clamped to the current line width
    always_comb
    begin
        col_ext    = WVW'(in_col_reg);
        col_clamp  = (col_ext >= w_eff) ? (w_eff - WVW'(1)) : col_ext;
        col_last   = (col_ext + WVW'(1)) >= w_eff;
        rcol_ext   = WVW'(rep_col_reg);
        rcol_clamp = (rcol_ext >= w_eff) ? (w_eff - WVW'(1)) : rcol_ext;
        rcol_last  = (rcol_ext + WVW'(1)) >= w_eff;
    end

    // Pattern steps for live column, replay column and rows
    always_comb
    begin
        col_step  = pat_step(col_pat_reg, !col_last, cfg.extra_num, cfg.extra_den);
        rcol_step = pat_step(rep_pat_reg, !rcol_last, cfg.extra_num, cfg.extra_den);
        need      = NW'(xrows_reg) + NW'(1) + (NW'(n_eff) * NW'(h_eff));
        row_fits  = need <= NW'(cfg.out_height);
        row_step  = pat_step(row_pat_reg, row_fits, cfg.extra_num, cfg.extra_den);
        row_inc   = HVW'(in_row_reg) + HVW'(1);
        frame_end = row_inc >= h_eff;
    end

    // Item decision and next state
    always_comb
    begin
        replay_req = item.action;
        pending    = (replays_reg != 6'd0);
        pix_in     = {item.red, item.green, item.blue};

        in_col_next  = in_col_reg;
        col_pat_next = col_pat_reg;
        in_row_next  = in_row_reg;
        row_pat_next = row_pat_reg;
        xrows_next   = xrows_reg;
        replays_next = replays_reg;
        rep_col_next = rep_col_reg;
        rep_pat_next = rep_pat_reg;

        load         = '0;
        wr_en        = 1'b0;
        wr_addr      = col_clamp[CW-1:0];
        wr_data      = pix_in;
        rd_en        = 1'b0;
        rd_addr      = rcol_clamp[CW-1:0];

        if (accept)
        begin
            if (replay_req)
            begin
                // Replay of a buffered pixel; nothing happens when none pending
                if (pending)
                begin
                    rd_en         = 1'b1;
                    load.valid    = 1'b1;
                    load.copies   = {1'b0, n_eff} + {6'd0, rcol_step[7]};
                    load.row_end  = rcol_last;
                    load.from_mem = 1'b1;
                    if (rcol_last)
                    begin
                        rep_col_next = '0;
                        rep_pat_next = 7'd0;
                        replays_next = replays_reg - 6'd1;
                    end
                    else
                    begin
                        rep_col_next = CW'(rcol_clamp + WVW'(1));
                        rep_pat_next = rcol_step[6:0];
                    end
                end
            end
            else if (pending)
            begin
                // Pixel dropped while row copies are still owed
                load.valid    = 1'b1;
                load.copies   = 7'd1;
                load.rejected = 1'b1;
            end
            else
            begin
                // Live pixel: store and send
                wr_en        = 1'b1;
                load.valid   = 1'b1;
                load.copies  = {1'b0, n_eff} + {6'd0, col_step[7]};
                load.row_end = col_last;
                load.pixel   = pix_in;
                if (col_last)
                begin
                    replays_next = n_eff - 6'd1 + {5'd0, row_step[7]};
                    rep_col_next = '0;
                    rep_pat_next = 7'd0;
                    in_col_next  = '0;
                    col_pat_next = 7'd0;
                    if (frame_end)
                    begin
                        in_row_next  = '0;
                        row_pat_next = 7'd0;
                        xrows_next   = '0;
                    end
                    else
                    begin
                        in_row_next  = row_inc[RW-1:0];
                        row_pat_next = row_step[6:0];
                        xrows_next   = xrows_reg + {{(RW-1){1'b0}}, row_step[7]};
                    end
                end
                else
                begin
                    in_col_next  = CW'(col_clamp + WVW'(1));
                    col_pat_next = col_step[6:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            col_pat_reg <= 7'd0;
            in_row_reg  <= '0;
            row_pat_reg <= 7'd0;
            xrows_reg   <= '0;
            replays_reg <= 6'd0;
            rep_col_reg <= '0;
            rep_pat_reg <= 7'd0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            col_pat_reg <= col_pat_next;
            in_row_reg  <= in_row_next;
            row_pat_reg <= row_pat_next;
            xrows_reg   <= xrows_next;
            replays_reg <= replays_next;
            rep_col_reg <= rep_col_next;
            rep_pat_reg <= rep_pat_next;
        end
    end

endmodule

// ===== rtl/core/frs_emit.sv =====
// Result register: sends one item per cycle while out_ready is high, until all copies of a pixel are out.
module frs_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  frs_pkg::frs_load_t  load,
    input  logic [23:0]         mem_data,
    input  logic                out_ready,
    output logic                out_valid,
    output frs_pkg::frs_out_t   out_item,
    output logic                free
);
    import frs_pkg::*;

    logic        busy_reg, busy_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        row_end_reg, row_end_next;
    logic        rej_reg, rej_next;
    logic        from_mem_reg, from_mem_next;
    logic [23:0] pix_reg, pix_next;

    logic        final_copy;
    logic [23:0] pix_out;

    assign final_copy = (cnt_reg == 7'd1);
    assign free       = !busy_reg || (out_ready && final_copy);

    // Copy counter and payload hold
    always_comb
    begin
        busy_next     = busy_reg;
        cnt_next      = cnt_reg;
        row_end_next  = row_end_reg;
        rej_next      = rej_reg;
        from_mem_next = from_mem_reg;
        pix_next      = pix_reg;
        if (busy_reg && out_ready)
        begin
            if (final_copy)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg - 7'd1;
        end
        if (free && load.valid)
        begin
            busy_next     = 1'b1;
            cnt_next      = load.copies;
            row_end_next  = load.row_end;
            rej_next      = load.rejected;
            from_mem_next = load.from_mem;
            pix_next      = load.pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_end_reg  <= row_end_next;
        rej_reg      <= rej_next;
        from_mem_reg <= from_mem_next;
        pix_reg      <= pix_next;
    end

    // Result fields
    assign pix_out            = from_mem_reg ? mem_data : pix_reg;
    assign out_valid          = busy_reg;
    assign out_item.out_blue  = pix_out[7:0];
    assign out_item.out_green = pix_out[15:8];
    assign out_item.out_red   = pix_out[23:16];
    assign out_item.last      = final_copy;
    assign out_item.line_end  = final_copy && row_end_reg;
    assign out_item.rejected  = rej_reg;

endmodule
